### hw/rtl/rba_pkg.sv
// Shared types and constants for the reference-counted block allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package rba_pkg;

    // Fixed field widths of the request and response beats.
    localparam int BC_W     = 11;
    localparam int ID_W     = 10;
    localparam int FREE_W   = 11;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;

    // Request actions.
    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_RETAIN  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RECYCLE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ    = 3'd4;

    // Response status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD       = 2'd2;

    // Strobes from the sequencer to the free list.
    typedef struct packed {
        logic rd;     // read the entry at the head pointer
        logic pop;    // advance the head pointer
        logic push;   // write an id at the tail pointer
        logic sweep;  // initialization pass is writing one entry
    } t_fl_cmd;

    // Strobes from the sequencer to the reference table.
    typedef struct packed {
        logic rd;     // read one entry
        logic wr;     // write one entry
        logic sweep;  // initialization pass is clearing one entry
    } t_rt_cmd;

endpackage

### hw/rtl/refcounted_block_allocator.sv
// Top level of the reference-counted block allocator: sequencer, register port
// and response register. Depends on rba_pkg, rba_free_list and rba_ref_table.
//
// Usage:
// A request beat (i_action, i_block_id) is taken on i_in_valid and o_in_ready.
// Each request gives exactly one response beat (o_status, o_result_id,
// o_count_out, o_free_count) on o_out_valid and i_out_ready.
// In the accept cycle the free-list head and the addressed table entry are
// read from their synchronous memories; in the execute cycle the entry is
// modified, written back and the response is registered. No new request is
// taken until the execute cycle has fired, so only one request is in flight
// and a write never overlaps a read of the same entry. If the receiver stalls
// and the response register is still full, the execute cycle waits until the
// waiting beat is taken. After reset, and after every write of block_count,
// an initialization pass loads the free list with ids 0..count-1 and clears
// all marks and counts; o_in_ready stays low during the pass. Register 0
// (block_count, byte address 0) is written over the APB port with pready high.
`timescale 1ns / 1ps

module refcounted_block_allocator #(
    parameter int POOL_DEPTH  = 1024,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rba_pkg::ACTION_W-1:0]  i_action,
    input  logic [rba_pkg::ID_W-1:0]      i_block_id,
    // Response channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rba_pkg::STATUS_W-1:0]  o_status,
    output logic [rba_pkg::ID_W-1:0]      o_result_id,
    output logic [COUNT_WIDTH-1:0]        o_count_out,
    output logic [rba_pkg::FREE_W-1:0]    o_free_count,
    // Register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rba_pkg::*;

    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int FW = $clog2(POOL_DEPTH + 1);
    localparam logic [BC_W-1:0] BC_RESET = (POOL_DEPTH < 1024) ? BC_W'(POOL_DEPTH)
                                                                : BC_W'(1024);
    localparam logic [AW-1:0] LAST_IDX = AW'(POOL_DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(POOL_DEPTH);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Sequencer states.
    localparam logic [1:0] S_SWEEP = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [AW-1:0]       r_sweep_idx;
    logic [BC_W-1:0]     r_block_count;
    logic [ACTION_W-1:0] r_act;
    logic [ID_W-1:0]     r_id;

    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_status;
    logic [ID_W-1:0]        r_result_id;
    logic [COUNT_WIDTH-1:0] r_count_out;
    logic [FREE_W-1:0]      r_free_count;

    t_fl_cmd             fl_cmd;
    t_rt_cmd             rt_cmd;
    logic [AW-1:0]       fl_rd_id;
    logic [FW-1:0]       fl_fill;
    logic                rt_used;
    logic [COUNT_WIDTH-1:0] rt_count;

    logic                cfg_wr;
    logic [BC_W-1:0]     cfg_bc;
    logic                accept;
    logic                sweeping;
    logic                exec_fire;

    logic [STATUS_W-1:0]    e_status;
    logic [ID_W-1:0]        e_rid;
    logic [COUNT_WIDTH-1:0] e_cnt;
    logic [FW-1:0]          e_fill;
    logic                   e_pop;
    logic                   e_push;
    logic                   e_wr;
    logic [AW-1:0]          e_wr_addr;
    logic                   e_wr_used;
    logic [COUNT_WIDTH-1:0] e_wr_count;
    logic                   id_ok;

    // Register port: block_count at index 0, clamped to 1..POOL_DEPTH.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = 32'(r_block_count);

    always_comb begin
        cfg_bc = pwdata[BC_W-1:0];
        if (cfg_bc == '0) begin
            cfg_bc = BC_W'(1);
        end else if (32'(cfg_bc) > 32'(POOL_DEPTH)) begin
            cfg_bc = BC_W'(POOL_DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= BC_RESET;
        end else if (cfg_wr) begin
            r_block_count <= cfg_bc;
        end
    end

    // Handshake qualifiers.
    assign sweeping   = (r_state == S_SWEEP);
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign exec_fire  = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // Sequencer: initialization pass, accept, execute.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_SWEEP: begin
                if (r_sweep_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_SWEEP;
        endcase
        if (cfg_wr) begin
            n_state = S_SWEEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep_idx <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_sweep_idx <= '0;
            end else if (sweeping) begin
                r_sweep_idx <= r_sweep_idx + AW'(1);
            end
        end
    end

    // Capture the request beat for the execute cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= i_action;
            r_id  <= i_block_id;
        end
    end

    // Execute: check the request against the read entry and build the response.
    assign id_ok = ({1'b0, r_id} < r_block_count);

    always_comb begin
        e_status   = STAT_OK;
        e_rid      = r_id;
        e_cnt      = '0;
        e_fill     = fl_fill;
        e_pop      = 1'b0;
        e_push     = 1'b0;
        e_wr       = 1'b0;
        e_wr_addr  = AW'(r_id);
        e_wr_used  = rt_used;
        e_wr_count = rt_count;
        if (r_act == ACT_ALLOC) begin
            if (fl_fill == '0) begin
                e_status = STAT_EXHAUSTED;
                e_rid    = '0;
            end else begin
                e_rid      = ID_W'(fl_rd_id);
                e_cnt      = COUNT_WIDTH'(1);
                e_fill     = fl_fill - FW'(1);
                e_pop      = 1'b1;
                e_wr       = 1'b1;
                e_wr_addr  = fl_rd_id;
                e_wr_used  = 1'b1;
                e_wr_count = COUNT_WIDTH'(1);
            end
        end else if (r_act > ACT_READ || !id_ok) begin
            e_status = STAT_BAD;
        end else begin
            e_cnt = rt_count;
            case (r_act)
                ACT_RETAIN: begin
                    if (!rt_used || rt_count == '0 || rt_count == CNT_MAX) begin
                        e_status = STAT_BAD;
                    end else begin
                        e_cnt      = rt_count + COUNT_WIDTH'(1);
                        e_wr       = 1'b1;
                        e_wr_count = rt_count + COUNT_WIDTH'(1);
                    end
                end
                ACT_RELEASE: begin
                    if (!rt_used || rt_count == '0) begin
                        e_status = STAT_BAD;
                    end else begin
                        e_cnt      = rt_count - COUNT_WIDTH'(1);
                        e_wr       = 1'b1;
                        e_wr_count = rt_count - COUNT_WIDTH'(1);
                    end
                end
                ACT_RECYCLE: begin
                    if (!rt_used || rt_count != '0 || fl_fill >= FILL_MAX) begin
                        e_status = STAT_BAD;
                    end else begin
                        e_fill    = fl_fill + FW'(1);
                        e_push    = 1'b1;
                        e_wr      = 1'b1;
                        e_wr_used = 1'b0;
                    end
                end
                default: begin
                    // A read only reports the count.
                    e_status = STAT_OK;
                end
            endcase
        end
    end

    // Memory commands.
    always_comb begin
        fl_cmd.rd    = accept;
        fl_cmd.pop   = exec_fire && e_pop;
        fl_cmd.push  = exec_fire && e_push;
        fl_cmd.sweep = sweeping;
        rt_cmd.rd    = accept;
        rt_cmd.wr    = exec_fire && e_wr;
        rt_cmd.sweep = sweeping;
    end

    rba_free_list #(
        .POOL_DEPTH (POOL_DEPTH),
        .AW         (AW),
        .FW         (FW)
    ) u_free_list (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (fl_cmd),
        .i_push_id     (AW'(r_id)),
        .i_sweep_idx   (r_sweep_idx),
        .i_block_count (r_block_count),
        .o_rd_id       (fl_rd_id),
        .o_fill        (fl_fill)
    );

    rba_ref_table #(
        .POOL_DEPTH  (POOL_DEPTH),
        .AW          (AW),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ref_table (
        .i_clk       (i_clk),
        .i_cmd       (rt_cmd),
        .i_rd_addr   (AW'(i_block_id)),
        .i_wr_addr   (e_wr_addr),
        .i_wr_used   (e_wr_used),
        .i_wr_count  (e_wr_count),
        .i_sweep_idx (r_sweep_idx),
        .o_used      (rt_used),
        .o_count     (rt_count)
    );

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_status     <= e_status;
            r_result_id  <= e_rid;
            r_count_out  <= e_cnt;
            r_free_count <= FREE_W'(e_fill);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_result_id  = r_result_id;
    assign o_count_out  = r_count_out;
    assign o_free_count = r_free_count;

endmodule

### hw/rtl/rba_free_list.sv
// FIFO free list of block ids: one synchronous memory plus head, tail and fill.
// Depends on rba_pkg for the command struct and the block count width.
`timescale 1ns / 1ps

module rba_free_list #(
    parameter int POOL_DEPTH = 1024,
    parameter int AW         = 10,
    parameter int FW         = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rba_pkg::t_fl_cmd     i_cmd,
    input  logic [AW-1:0]        i_push_id,
    input  logic [AW-1:0]        i_sweep_idx,
    input  logic [rba_pkg::BC_W-1:0] i_block_count,
    output logic [AW-1:0]        o_rd_id,
    output logic [FW-1:0]        o_fill
);
    import rba_pkg::*;

    localparam int CMPW = (AW > BC_W) ? AW : BC_W;
    localparam logic [AW-1:0] LAST_PTR = AW'(POOL_DEPTH - 1);

    logic [AW-1:0] r_mem [POOL_DEPTH];
    logic [AW-1:0] r_rd_id;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [FW-1:0] r_fill;

    logic [AW-1:0] sweep_val;
    logic [AW-1:0] tail_init;

    // Initial contents: ids below the block count in order, zero beyond.
    assign sweep_val = (CMPW'(i_sweep_idx) < CMPW'(i_block_count)) ? i_sweep_idx : '0;
    assign tail_init = (CMPW'(i_block_count) == CMPW'(POOL_DEPTH)) ? '0
                                                                    : AW'(i_block_count);

    // Memory write and registered head read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            r_mem[i_sweep_idx] <= sweep_val;
        end else if (i_cmd.push) begin
            r_mem[r_tail] <= i_push_id;
        end
        if (i_cmd.rd) begin
            r_rd_id <= r_mem[r_head];
        end
    end

    // Pointers and fill; the initialization pass holds them at their start values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else if (i_cmd.sweep) begin
            r_head <= '0;
            r_tail <= tail_init;
            r_fill <= FW'(i_block_count);
        end else begin
            if (i_cmd.pop) begin
                r_head <= (r_head == LAST_PTR) ? '0 : r_head + AW'(1);
                r_fill <= r_fill - FW'(1);
            end
            if (i_cmd.push) begin
                r_tail <= (r_tail == LAST_PTR) ? '0 : r_tail + AW'(1);
                r_fill <= r_fill + FW'(1);
            end
        end
    end

    assign o_rd_id = r_rd_id;
    assign o_fill  = r_fill;

endmodule

### hw/rtl/rba_ref_table.sv
// Per-block state table: in-use mark and reference count in one synchronous memory.
// Depends on rba_pkg for the command struct.
`timescale 1ns / 1ps

module rba_ref_table #(
    parameter int POOL_DEPTH  = 1024,
    parameter int AW          = 10,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  rba_pkg::t_rt_cmd       i_cmd,
    input  logic [AW-1:0]          i_rd_addr,
    input  logic [AW-1:0]          i_wr_addr,
    input  logic                   i_wr_used,
    input  logic [COUNT_WIDTH-1:0] i_wr_count,
    input  logic [AW-1:0]          i_sweep_idx,
    output logic                   o_used,
    output logic [COUNT_WIDTH-1:0] o_count
);
    import rba_pkg::*;

    logic [COUNT_WIDTH:0] r_mem [POOL_DEPTH];
    logic [COUNT_WIDTH:0] r_rd;

    // The clearing pass takes the write port; otherwise the sequencer owns it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            r_mem[i_sweep_idx] <= '0;
        end else if (i_cmd.wr) begin
            r_mem[i_wr_addr] <= {i_wr_used, i_wr_count};
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_used  = r_rd[COUNT_WIDTH];
    assign o_count = r_rd[COUNT_WIDTH-1:0];

endmodule

### tb/tb_top.sv
// Self-checking testbench for refcounted_block_allocator: a directed opening, random
// lifecycle traffic over several pool sizes and a back-to-back stretch on one block.
// Depends on rba_pkg and the allocator RTL; the pool is predicted inside this file.
`timescale 1ns / 1ps

module tb_top;
    import rba_pkg::*;

    localparam int POOL_DEPTH   = 1024;
    localparam int COUNT_WIDTH  = 16;
    localparam int PTR_W        = $clog2(POOL_DEPTH);
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int HOLD_AT      = 333;
    localparam int HOLD_CYCLES  = 160;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [FREE_W-1:0]      FILL_FULL = FREE_W'(POOL_DEPTH);

    localparam logic [2:0]          REG_BLOCK_COUNT  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN_LO   = ACT_READ + 3'd1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ID_W-1:0]     block_id;
    } t_alloc_req;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ID_W-1:0]        result_id;
        logic [COUNT_WIDTH-1:0] count;
        logic [FREE_W-1:0]      free_count;
    } t_alloc_resp;

    // Block ports; the inputs are known from time zero.
    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_in_valid   = 1'b0;
    logic                   o_in_ready;
    logic [ACTION_W-1:0]    i_action     = '0;
    logic [ID_W-1:0]        i_block_id   = '0;
    logic                   o_out_valid;
    logic                   i_out_ready  = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic [ID_W-1:0]        o_result_id;
    logic [COUNT_WIDTH-1:0] o_count_out;
    logic [FREE_W-1:0]      o_free_count;
    logic                   psel         = 1'b0;
    logic                   penable      = 1'b0;
    logic                   pwrite       = 1'b0;
    logic [2:0]             paddr        = '0;
    logic [31:0]            pwdata       = '0;
    logic [31:0]            prdata;
    logic                   pready;

    refcounted_block_allocator #(
        .POOL_DEPTH  (POOL_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_block_id   (i_block_id),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_result_id  (o_result_id),
        .o_count_out  (o_count_out),
        .o_free_count (o_free_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Bookkeeping shared by the processes below.
    t_alloc_req  request_backlog [$];
    t_alloc_resp expected_resps [$];
    int          mismatch_n  = 0;
    int          req_taken_n = 0;
    int          resp_seen_n = 0;
    int          config_n    = 0;
    int          cycle_n     = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    bit          steady      = 1'b0;

    // Predicted pool state.
    logic [BC_W-1:0]        pool_size;
    logic [ID_W-1:0]        pool_fifo [POOL_DEPTH];
    logic [PTR_W-1:0]       pool_head;
    logic [PTR_W-1:0]       pool_tail;
    logic [FREE_W-1:0]      pool_fill;
    bit                     pool_busy [POOL_DEPTH];
    logic [COUNT_WIDTH-1:0] pool_refs [POOL_DEPTH];

    // Stimulus-side view of which blocks are live, used to build legal lifecycles.
    int plan_size;
    int plan_free [$];
    int plan_live [$];
    bit plan_busy [POOL_DEPTH];
    int plan_refs [POOL_DEPTH];

    // A block count write clamps to 1..POOL_DEPTH and reloads the whole pool.
    function automatic void pool_rebuild(input logic [31:0] value);
        logic [BC_W-1:0] n;
        n = value[BC_W-1:0];
        if (n == '0) begin
            n = BC_W'(1);
        end else if (32'(n) > POOL_DEPTH) begin
            n = BC_W'(POOL_DEPTH);
        end
        pool_size = n;
        for (int i = 0; i < POOL_DEPTH; i++) begin
            pool_fifo[i] = (i < 32'(n)) ? ID_W'(i) : '0;
            pool_busy[i] = 1'b0;
            pool_refs[i] = '0;
        end
        pool_head = '0;
        pool_tail = PTR_W'(n);
        pool_fill = FREE_W'(n);
    endfunction

    // Applies one request to the predicted pool and returns the response it causes.
    function automatic t_alloc_resp pool_apply(input t_alloc_req req);
        t_alloc_resp            r;
        logic [COUNT_WIDTH-1:0] c;
        logic [ID_W-1:0]        id;
        id          = req.block_id;
        r.status    = STAT_OK;
        r.result_id = id;
        r.count     = '0;
        if (req.action == ACT_ALLOC) begin
            if (pool_fill == '0) begin
                r.status    = STAT_EXHAUSTED;
                r.result_id = '0;
            end else begin
                r.result_id = pool_fifo[pool_head];
                pool_head   = pool_head + PTR_W'(1);
                pool_fill   = pool_fill - FREE_W'(1);
                pool_busy[r.result_id] = 1'b1;
                pool_refs[r.result_id] = COUNT_WIDTH'(1);
                r.count = COUNT_WIDTH'(1);
            end
        end else if (req.action > ACT_READ || {1'b0, id} >= pool_size) begin
            r.status = STAT_BAD;
        end else begin
            c       = pool_refs[id];
            r.count = c;
            case (req.action)
                ACT_RETAIN: begin
                    if (!pool_busy[id] || c == '0 || c == COUNT_MAX) begin
                        r.status = STAT_BAD;
                    end else begin
                        r.count       = c + COUNT_WIDTH'(1);
                        pool_refs[id] = r.count;
                    end
                end
                ACT_RELEASE: begin
                    if (!pool_busy[id] || c == '0) begin
                        r.status = STAT_BAD;
                    end else begin
                        r.count       = c - COUNT_WIDTH'(1);
                        pool_refs[id] = r.count;
                    end
                end
                ACT_RECYCLE: begin
                    if (!pool_busy[id] || c != '0 || pool_fill >= FILL_FULL) begin
                        r.status = STAT_BAD;
                    end else begin
                        pool_busy[id]        = 1'b0;
                        pool_fifo[pool_tail] = id;
                        pool_tail            = pool_tail + PTR_W'(1);
                        pool_fill            = pool_fill + FREE_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
        r.free_count = pool_fill;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatch_n++;
            $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    task automatic queue_request(input logic [ACTION_W-1:0] action, input int id);
        t_alloc_req r;
        r.action   = action;
        r.block_id = id[ID_W-1:0];
        request_backlog = {request_backlog, r};
    endtask

    task automatic plan_reset();
        plan_size = int'(pool_size);
        plan_free.delete();
        plan_live.delete();
        for (int i = 0; i < POOL_DEPTH; i++) begin
            plan_busy[i] = 1'b0;
            plan_refs[i] = 0;
            if (i < plan_size) begin
                plan_free = {plan_free, i};
            end
        end
    endtask

    // Mostly legal lifecycles on live blocks; the rest is noise that never alters
    // the pool, so the stimulus-side view stays exact.
    task automatic plan_random_request();
        int pick;
        int k;
        int id;
        pick = $urandom_range(99);
        id   = $urandom_range(POOL_DEPTH - 1);
        if (pick >= 30 && pick < 85 && plan_live.size() == 0) begin
            pick = 0;
        end
        if (pick < 30) begin
            // The id bits of an allocate are random; the block ignores them.
            if (plan_free.size() > 0) begin
                k = plan_free[0];
                plan_free.delete(0);
                plan_live = {plan_live, k};
                plan_busy[k] = 1'b1;
                plan_refs[k] = 1;
            end
            queue_request(ACT_ALLOC, id);
        end else if (pick < 85) begin
            k  = $urandom_range(plan_live.size() - 1);
            id = plan_live[k];
            if (pick < 50) begin
                if (plan_refs[id] > 0) begin
                    plan_refs[id]++;
                end
                queue_request(ACT_RETAIN, id);
            end else if (pick < 72) begin
                if (plan_refs[id] > 0) begin
                    plan_refs[id]--;
                end
                queue_request(ACT_RELEASE, id);
            end else begin
                // A recycle with references left is a broken sequence and must fail.
                if (plan_refs[id] == 0) begin
                    plan_live.delete(k);
                    plan_busy[id] = 1'b0;
                    plan_free = {plan_free, id};
                end
                queue_request(ACT_RECYCLE, id);
            end
        end else if (pick < 90) begin
            queue_request(ACT_READ, id);
        end else if (pick < 94) begin
            queue_request(ACT_UNKNOWN_LO + 3'($urandom_range(2)), id);
        end else if (id < plan_size && plan_busy[id]) begin
            queue_request(ACT_READ, id);
        end else begin
            queue_request(ACT_RETAIN + 3'($urandom_range(2)), id);
        end
    endtask

    // Waits until no request is queued or on the wire and every response is in.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (request_backlog.size() != 0 || i_in_valid || expected_resps.size() != 0);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic set_pool_size(input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_BLOCK_COUNT;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pool_rebuild(value);
        plan_reset();
        config_n++;
    endtask

    task automatic run_random_phase(input logic [31:0] value, input int n);
        set_pool_size(value);
        repeat (n) plan_random_request();
        wait_idle();
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n >= CYCLE_LIMIT) begin
            $display("%0t ns: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Request driver: predicts each beat as it is accepted, then offers the next.
    always @(posedge i_clk) begin
        t_alloc_req  req;
        t_alloc_resp pred;
        if (i_in_valid && o_in_ready) begin
            req.action   = i_action;
            req.block_id = i_block_id;
            pred         = pool_apply(req);
            expected_resps = {expected_resps, pred};
            req_taken_n <= req_taken_n + 1;
        end
        if (!i_in_valid || o_in_ready) begin
            if (request_backlog.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
                req = request_backlog[0];
                request_backlog.delete(0);
                i_in_valid <= 1'b1;
                i_action   <= req.action;
                i_block_id <= req.block_id;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Response ready: random stalls, plus one long hold-off while requests keep coming.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && resp_seen_n >= HOLD_AT) begin
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_ready <= steady || ($urandom_range(99) >= 27);
        end
    end

    // Response monitor: each beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_alloc_resp want;
        if (o_out_valid && i_out_ready) begin
            resp_seen_n <= resp_seen_n + 1;
            if (expected_resps.size() == 0) begin
                mismatch_n++;
                $display("%0t ns: extra response: expected none, actual status %0d id %0d",
                         $time, o_status, o_result_id);
            end else begin
                want = expected_resps[0];
                expected_resps.delete(0);
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("result_id", 32'(want.result_id), 32'(o_result_id));
                check_field("count_out", 32'(want.count), 32'(o_count_out));
                check_field("free_count", 32'(want.free_count), 32'(o_free_count));
            end
        end
    end

    // Stimulus sequence.
    initial begin
        pool_rebuild(32'd1024);
        plan_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full pool after reset: free-block errors, a full lifecycle, unknown actions.
        queue_request(ACT_READ, 0);
        queue_request(ACT_RETAIN, 0);
        queue_request(ACT_RELEASE, 0);
        queue_request(ACT_ALLOC, 1023);
        queue_request(ACT_RETAIN, 0);
        queue_request(ACT_RELEASE, 0);
        queue_request(ACT_RELEASE, 0);
        queue_request(ACT_RELEASE, 0);
        queue_request(ACT_RETAIN, 0);
        queue_request(ACT_RECYCLE, 0);
        queue_request(ACT_RECYCLE, 0);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_RECYCLE, 1);
        queue_request(ACT_READ, 1023);
        queue_request(ACT_UNKNOWN_LO, 1023);
        queue_request(ACT_UNKNOWN_LO + 3'd1, 512);
        queue_request(ACT_UNKNOWN_LO + 3'd2, 0);
        wait_idle();

        // Single-block pool: exhaustion and ids past the end.
        set_pool_size(32'd1);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_READ, 1);
        queue_request(ACT_RETAIN, 1023);
        queue_request(ACT_RELEASE, 0);
        queue_request(ACT_RECYCLE, 0);
        queue_request(ACT_ALLOC, 0);
        wait_idle();

        // Random traffic: clamped extremes, small pools, full size, masked upper bits.
        run_random_phase(32'd0, 60);
        run_random_phase(32'd2047, 150);
        repeat (4) run_random_phase($urandom_range(12, 2), 120);
        run_random_phase(32'd1024, 130);
        run_random_phase(32'hFFFF_F805, 80);

        // Back-to-back retains on one block with no idling on either side.
        steady = 1'b1;
        set_pool_size(32'd3);
        queue_request(ACT_ALLOC, 0);
        repeat (20) queue_request(ACT_RETAIN, 0);
        queue_request(ACT_RELEASE, 0);
        queue_request(ACT_READ, 0);
        wait_idle();
        steady = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_resps.size() != 0) begin
            mismatch_n++;
            $display("%0t ns: responses outstanding at end: expected 0, actual %0d",
                     $time, expected_resps.size());
        end

        $display("Checked %0d responses to %0d requests over %0d block count writes.",
                 resp_seen_n, req_taken_n, config_n);
        $display("Covered exhaustion, bad ids and states, unknown actions, a %0d-cycle stall.",
                 HOLD_CYCLES);
        if (mismatch_n == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
